@@ hw/rtl/pli_pkg.sv @@
// Shared constants and types for the piecewise-linear interpolation block.
package pli_pkg;

   localparam int MAX_KNOTS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int KNOT_IDX_W      = 4;
   localparam int KNOT_CNT_W      = 5;
   localparam int INTEG_W         = 64;
   localparam int REGION_W        = 2;
   localparam int MUL_CHUNK       = 17;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [REGION_W-1:0] REGION_LEFT  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_INNER = 2'd1;
   localparam logic [REGION_W-1:0] REGION_RIGHT = 2'd2;

   typedef struct packed {
      logic                  is_query;
      logic [KNOT_IDX_W-1:0] idx;
   } job_ctl_type;

endpackage

@@ hw/rtl/pli_front.sv @@
// Front end: takes request beats, holds the knot count and queues jobs for the back end.
module pli_front #(
   parameter int MAX_KNOTS   = 16,
   parameter int COORD_WIDTH = 32,
   parameter int AW          = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_type,
   input  logic [pli_pkg::KNOT_IDX_W-1:0]    req_knot_index,
   input  logic [COORD_WIDTH-1:0]            req_knot_x,
   input  logic [COORD_WIDTH-1:0]            req_knot_y,
   input  logic [COORD_WIDTH-1:0]            req_query_x,
   input  logic                              csr_write,
   input  logic [pli_pkg::KNOT_CNT_W-1:0]    csr_knot_count,
   output logic                              job_valid,
   input  logic                              job_take,
   output pli_pkg::job_ctl_type              job_ctl,
   output logic [COORD_WIDTH-1:0]            job_x,
   output logic [COORD_WIDTH-1:0]            job_y,
   output logic [COORD_WIDTH-1:0]            job_q,
   output logic [AW-1:0]                     job_nm1
);
   import pli_pkg::*;

   localparam int NW = $clog2(MAX_KNOTS + 1);
   localparam int KW = (NW > KNOT_CNT_W) ? NW : KNOT_CNT_W;

   job_ctl_type            ctl_ff [2];
   logic [COORD_WIDTH-1:0] x_ff [2];
   logic [COORD_WIDTH-1:0] y_ff [2];
   logic [COORD_WIDTH-1:0] q_ff [2];
   logic [AW-1:0]          nm1_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic [KNOT_CNT_W-1:0]  kc_ff, kc_in;
   logic [KW-1:0]          kc_ext;
   logic [AW-1:0]          nm1;
   logic                   push_ok;
   logic                   take_ok;

   assign req_full  = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign push_ok   = req_push && !req_full;
   assign take_ok   = job_take && job_valid;

   assign job_ctl = ctl_ff[rd_ptr_ff];
   assign job_x   = x_ff[rd_ptr_ff];
   assign job_y   = y_ff[rd_ptr_ff];
   assign job_q   = q_ff[rd_ptr_ff];
   assign job_nm1 = nm1_ff[rd_ptr_ff];

   always_comb begin
      kc_ext = KW'(kc_ff);
      if (kc_ext == '0) begin
         nm1 = '0;
      end else if (kc_ext > KW'(MAX_KNOTS)) begin
         nm1 = AW'(MAX_KNOTS - 1);
      end else begin
         nm1 = AW'(kc_ext - KW'(1));
      end
      kc_in     = csr_write ? csr_knot_count : kc_ff;
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         kc_ff     <= KNOT_CNT_W'(1);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         kc_ff     <= kc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         ctl_ff[wr_ptr_ff].is_query <= (req_type == REQ_QUERY);
         ctl_ff[wr_ptr_ff].idx      <= req_knot_index;
         x_ff[wr_ptr_ff]            <= req_knot_x;
         y_ff[wr_ptr_ff]            <= req_knot_y;
         q_ff[wr_ptr_ff]            <= req_query_x;
         nm1_ff[wr_ptr_ff]          <= nm1;
      end
   end

endmodule

@@ hw/rtl/pli_back.sv @@
// Back end: knot table, search and trapezium sequencer, divider and result register.
module pli_back #(
   parameter int MAX_KNOTS   = 16,
   parameter int COORD_WIDTH = 32,
   parameter int AW          = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_take,
   input  pli_pkg::job_ctl_type              job_ctl,
   input  logic [COORD_WIDTH-1:0]            job_x,
   input  logic [COORD_WIDTH-1:0]            job_y,
   input  logic [COORD_WIDTH-1:0]            job_q,
   input  logic [AW-1:0]                     job_nm1,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [COORD_WIDTH-1:0]            rsp_curve_value,
   output logic [pli_pkg::INTEG_W-1:0]       rsp_curve_integral,
   output logic [pli_pkg::REGION_W-1:0]      rsp_region,
   output logic                              rsp_saturated
);
   import pli_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int MW    = W + 1;
   localparam int CH    = MUL_CHUNK;
   localparam int NCH   = (MW + CH - 1) / CH;
   localparam int BW    = NCH * CH;
   localparam int PW    = MW + BW;
   localparam int ACC_W = PW + 10;
   localparam int FW    = ACC_W - 1;
   localparam int EXT_W = (FW > INTEG_W + 1) ? FW : INTEG_W + 1;
   localparam int SW    = $clog2(MW + 1);
   localparam int IW    = (AW > KNOT_IDX_W) ? AW : KNOT_IDX_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FETCH = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_ACC   = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_VAL   = 4'd6;
   localparam logic [3:0] ST_LAST  = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   localparam logic [1:0] OP_TRAP = 2'd0;
   localparam logic [1:0] OP_DBL  = 2'd1;
   localparam logic [1:0] OP_SUM  = 2'd2;
   localparam logic [1:0] OP_DIVN = 2'd3;

   logic [2*W-1:0]            mem [MAX_KNOTS];
   logic [2*W-1:0]            rd_ff;
   logic [2*W-1:0]            prev_ff, prev_in;
   logic [3:0]                state_ff, state_in;
   logic [AW-1:0]             i_ff, i_in;
   logic [AW-1:0]             nm1_ff, nm1_in;
   logic signed [MW-1:0]      q_ff, q_in;
   logic signed [MW-1:0]      ux_ff, ux_in;
   logic signed [MW-1:0]      t_ff, t_in;
   logic                      dneg_ff, dneg_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [MW-1:0]             ua_ff, ua_in;
   logic [BW-1:0]             ub_ff, ub_in;
   logic                      mneg_ff, mneg_in;
   logic [PW-1:0]             prod_ff, prod_in;
   logic [1:0]                mop_ff, mop_in;
   logic [SW-1:0]             cnt_ff, cnt_in;
   logic [MW:0]               rem_ff, rem_in;
   logic [MW-1:0]             nlo_ff, nlo_in;
   logic [MW-1:0]             den_ff, den_in;
   logic [MW-1:0]             quo_ff, quo_in;
   logic [W-1:0]              value_ff, value_in;
   logic [REGION_W-1:0]       region_ff, region_in;
   logic                      out_valid_ff, out_valid_in;
   logic [W-1:0]              o_value_ff, o_value_in;
   logic [INTEG_W-1:0]        o_integ_ff, o_integ_in;
   logic [REGION_W-1:0]       o_region_ff, o_region_in;
   logic                      o_sat_ff, o_sat_in;

   logic                      mst;
   logic signed [MW-1:0]      ma, mb;
   logic [1:0]                mop;
   logic signed [MW-1:0]      cx, cy, px, py, val_s, qv;
   logic [MW+CH-1:0]          part;
   logic [ACC_W-1:0]          p_u;
   logic signed [ACC_W-1:0]   p_s, d1;
   logic [MW:0]               rs;
   logic [EXT_W-1:0]          ext;
   logic                      sat;
   logic                      wr_en, rd_en, fin_fire;
   logic [IW-1:0]             widx;

   assign job_take           = (state_ff == ST_IDLE);
   assign rsp_empty          = !out_valid_ff;
   assign rsp_curve_value    = o_value_ff;
   assign rsp_curve_integral = o_integ_ff;
   assign rsp_region         = o_region_ff;
   assign rsp_saturated      = o_sat_ff;

   always_comb begin
      cx   = MW'($signed(rd_ff[2*W-1:W]));
      cy   = MW'($signed(rd_ff[W-1:0]));
      px   = MW'($signed(prev_ff[2*W-1:W]));
      py   = MW'($signed(prev_ff[W-1:0]));
      qv   = $signed(quo_ff);
      val_s = dneg_ff ? (py - qv) : (py + qv);
      part = ua_ff * ub_ff[cnt_ff*CH +: CH];
      p_u  = ACC_W'(prod_ff);
      p_s  = $signed(mneg_ff ? (~p_u + ACC_W'(1)) : p_u);
      rs   = {rem_ff[MW-1:0], nlo_ff[MW-1]};
      d1   = acc_ff + ACC_W'(1);
      ext  = EXT_W'($signed(d1[ACC_W-1:1]));
      sat  = (ext[EXT_W-1:INTEG_W-1] != {(EXT_W-INTEG_W+1){ext[INTEG_W-1]}});
      widx = IW'(job_ctl.idx);

      state_in     = state_ff;
      i_in         = i_ff;
      nm1_in       = nm1_ff;
      q_in         = q_ff;
      ux_in        = ux_ff;
      t_in         = t_ff;
      dneg_in      = dneg_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      value_in     = value_ff;
      region_in    = region_ff;
      o_value_in   = o_value_ff;
      o_integ_in   = o_integ_ff;
      o_region_in  = o_region_ff;
      o_sat_in     = o_sat_ff;
      mst          = 1'b0;
      ma           = '0;
      mb           = '0;
      mop          = OP_SUM;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      fin_fire     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job_ctl.is_query) begin
                  q_in     = MW'($signed(job_q));
                  nm1_in   = job_nm1;
                  i_in     = '0;
                  acc_in   = '0;
                  state_in = ST_FETCH;
               end else begin
                  wr_en = ({1'b0, widx} < (IW+1)'(MAX_KNOTS));
               end
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cx > q_ff) begin
               if (i_ff == '0) begin
                  region_in = REGION_LEFT;
                  value_in  = rd_ff[W-1:0];
                  mst = 1'b1;
                  ma  = q_ff - cx;
                  mb  = cy;
                  mop = OP_DBL;
               end else begin
                  region_in = REGION_INNER;
                  ux_in     = cx;
                  dneg_in   = (cy < py);
                  t_in      = q_ff - px;
                  mst = 1'b1;
                  ma  = cy - py;
                  mb  = q_ff - px;
                  mop = OP_DIVN;
               end
            end else begin
               prev_in = rd_ff;
               if (i_ff != '0) begin
                  mst = 1'b1;
                  ma  = cy + py;
                  mb  = cx - px;
                  mop = OP_TRAP;
               end else if (i_ff == nm1_ff) begin
                  state_in = ST_LAST;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_LAST: begin
            region_in = REGION_RIGHT;
            value_in  = prev_ff[W-1:0];
            mst = 1'b1;
            ma  = py;
            mb  = q_ff - px;
            mop = OP_DBL;
         end
         ST_MUL: begin
            prod_in = prod_ff + (PW'(part) << (CH*cnt_ff));
            if (cnt_ff == SW'(NCH - 1)) begin
               state_in = ST_ACC;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         ST_ACC: begin
            unique case (mop_ff)
               OP_TRAP: begin
                  acc_in = acc_ff + p_s;
                  if (i_ff == nm1_ff) begin
                     state_in = ST_LAST;
                  end else begin
                     i_in     = i_ff + AW'(1);
                     state_in = ST_FETCH;
                  end
               end
               OP_DBL: begin
                  acc_in   = acc_ff + p_s + p_s;
                  state_in = ST_FIN;
               end
               OP_SUM: begin
                  acc_in   = acc_ff + p_s;
                  state_in = ST_FIN;
               end
               OP_DIVN: begin
                  rem_in   = (MW+1)'(prod_ff >> MW);
                  nlo_in   = prod_ff[MW-1:0];
                  den_in   = MW'(ux_ff - px);
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_DIV: begin
            if (rs >= {1'b0, den_ff}) begin
               rem_in = rs - {1'b0, den_ff};
               quo_in = {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = rs;
               quo_in = {quo_ff[MW-2:0], 1'b0};
            end
            nlo_in = {nlo_ff[MW-2:0], 1'b0};
            if (cnt_ff == SW'(MW - 1)) begin
               state_in = ST_VAL;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         ST_VAL: begin
            value_in = val_s[W-1:0];
            mst = 1'b1;
            ma  = val_s + py;
            mb  = t_ff;
            mop = OP_SUM;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_pop) begin
               fin_fire    = 1'b1;
               o_value_in  = value_ff;
               o_region_in = region_ff;
               o_sat_in    = sat;
               if (sat) begin
                  o_integ_in = ext[EXT_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
               end else begin
                  o_integ_in = ext[INTEG_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (mst) begin
         ua_in    = ma[MW-1] ? MW'(-ma) : MW'(ma);
         ub_in    = BW'(mb[MW-1] ? MW'(-mb) : MW'(mb));
         mneg_in  = ma[MW-1] ^ mb[MW-1];
         mop_in   = mop;
         prod_in  = '0;
         cnt_in   = '0;
         state_in = ST_MUL;
      end else begin
         ua_in   = ua_ff;
         ub_in   = ub_ff;
         mneg_in = mneg_ff;
         mop_in  = mop_ff;
      end

      out_valid_in = fin_fire || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      nm1_ff      <= nm1_in;
      q_ff        <= q_in;
      ux_ff       <= ux_in;
      t_ff        <= t_in;
      dneg_ff     <= dneg_in;
      acc_ff      <= acc_in;
      prev_ff     <= prev_in;
      ua_ff       <= ua_in;
      ub_ff       <= ub_in;
      mneg_ff     <= mneg_in;
      prod_ff     <= prod_in;
      mop_ff      <= mop_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      nlo_ff      <= nlo_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      value_ff    <= value_in;
      region_ff   <= region_in;
      o_value_ff  <= o_value_in;
      o_integ_ff  <= o_integ_in;
      o_region_ff <= o_region_in;
      o_sat_ff    <= o_sat_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[widx[AW-1:0]] <= {job_x, job_y};
      end
      if (rd_en) begin
         rd_ff <= mem[i_ff];
      end
   end

endmodule

@@ hw/rtl/piecewise_linear_interp_integral_top.sv @@
// Piecewise-linear curve with flat extrapolation and its saturating running integral.
// A load beat is written to the knot table from the idle state; the front queue holds two beats.
// A query between knots runs the chunked multiplier, with NCH = ceil((COORD_WIDTH+1)/17) chunks,
// and the one-bit divider; outside the knots there is no division. Queries run one at a time.
// Reset clears the control state and sets knot_count to 1; the knot table is not cleared.
module piecewise_linear_interp_integral_top #(
   parameter int MAX_KNOTS   = pli_pkg::MAX_KNOTS_DEF,
   parameter int COORD_WIDTH = pli_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_type,
   input  logic [pli_pkg::KNOT_IDX_W-1:0]    req_knot_index,
   input  logic [COORD_WIDTH-1:0]            req_knot_x,
   input  logic [COORD_WIDTH-1:0]            req_knot_y,
   input  logic [COORD_WIDTH-1:0]            req_query_x,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [COORD_WIDTH-1:0]            rsp_curve_value,
   output logic [pli_pkg::INTEG_W-1:0]       rsp_curve_integral,
   output logic [pli_pkg::REGION_W-1:0]      rsp_region,
   output logic                              rsp_saturated,
   input  logic                              csr_write,
   input  logic [pli_pkg::KNOT_CNT_W-1:0]    csr_knot_count
);
   import pli_pkg::*;

   localparam int AW = $clog2(MAX_KNOTS);

   logic                   job_valid;
   logic                   job_take;
   job_ctl_type            job_ctl;
   logic [COORD_WIDTH-1:0] job_x;
   logic [COORD_WIDTH-1:0] job_y;
   logic [COORD_WIDTH-1:0] job_q;
   logic [AW-1:0]          job_nm1;

   pli_front #(
      .MAX_KNOTS   (MAX_KNOTS),
      .COORD_WIDTH (COORD_WIDTH),
      .AW          (AW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_knot_index (req_knot_index),
      .req_knot_x     (req_knot_x),
      .req_knot_y     (req_knot_y),
      .req_query_x    (req_query_x),
      .csr_write      (csr_write),
      .csr_knot_count (csr_knot_count),
      .job_valid      (job_valid),
      .job_take       (job_take),
      .job_ctl        (job_ctl),
      .job_x          (job_x),
      .job_y          (job_y),
      .job_q          (job_q),
      .job_nm1        (job_nm1)
   );

   pli_back #(
      .MAX_KNOTS   (MAX_KNOTS),
      .COORD_WIDTH (COORD_WIDTH),
      .AW          (AW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job_take           (job_take),
      .job_ctl            (job_ctl),
      .job_x              (job_x),
      .job_y              (job_y),
      .job_q              (job_q),
      .job_nm1            (job_nm1),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_curve_value    (rsp_curve_value),
      .rsp_curve_integral (rsp_curve_integral),
      .rsp_region         (rsp_region),
      .rsp_saturated      (rsp_saturated)
   );

endmodule

@@ tb/tb_piecewise_linear_interp_integral_top.sv @@
// Self-checking testbench for the piecewise-linear curve and integral block.
`timescale 1ns / 100ps

module tb_piecewise_linear_interp_integral_top;
   import pli_pkg::*;

   typedef logic signed [127:0] area_type;

   typedef struct {
      logic [31:0] value;
      logic [63:0] integral;
      logic [1:0]  region;
      logic        saturated;
   } curve_answer_type;

   localparam int SETTLE_CYCLES = 300;
   localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] X_MAX = 32'sh7FFF_FFFF;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_type;
   logic [3:0]  req_knot_index;
   logic [31:0] req_knot_x;
   logic [31:0] req_knot_y;
   logic [31:0] req_query_x;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_curve_value;
   logic [63:0] rsp_curve_integral;
   logic [1:0]  rsp_region;
   logic        rsp_saturated;
   logic        csr_write;
   logic [4:0]  csr_knot_count;

   logic signed [31:0] table_x [16];
   logic signed [31:0] table_y [16];
   logic [4:0]         count_reg;
   curve_answer_type   pending_answers[$];
   int                 failures;
   int                 beats_sent;
   int                 send_idle_pct;
   int                 pop_idle_pct;

   piecewise_linear_interp_integral_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_knot_index     (req_knot_index),
      .req_knot_x         (req_knot_x),
      .req_knot_y         (req_knot_y),
      .req_query_x        (req_query_x),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_curve_value    (rsp_curve_value),
      .rsp_curve_integral (rsp_curve_integral),
      .rsp_region         (rsp_region),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_knot_count     (csr_knot_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic curve_answer_type evaluate_curve(logic signed [31:0] qx);
      curve_answer_type ans;
      int       n;
      int       k;
      longint   q, lx, ly, ux, uy, dy, val;
      area_type twice_area, quo;
      n = (count_reg < 1) ? 1 : (count_reg > 16) ? 16 : count_reg;
      q = qx;
      k = n;
      for (int i = 0; i < n; i++) begin
         if (longint'(table_x[i]) > q) begin
            k = i;
            break;
         end
      end
      twice_area = 0;
      if (k == 0) begin
         val = table_y[0];
         ans.region = REGION_LEFT;
         twice_area = area_type'(q - longint'(table_x[0])) * area_type'(val) * 2;
      end else begin
         lx = table_x[k-1];
         ly = table_y[k-1];
         for (int i = 1; i < k; i++)
            twice_area = twice_area
               + area_type'(longint'(table_y[i-1]) + longint'(table_y[i]))
               * area_type'(longint'(table_x[i]) - longint'(table_x[i-1]));
         if (k == n) begin
            val = ly;
            ans.region = REGION_RIGHT;
            twice_area = twice_area + area_type'(ly) * area_type'(q - lx) * 2;
         end else begin
            ux = table_x[k];
            uy = table_y[k];
            dy = uy - ly;
            quo = (area_type'(dy) * area_type'(q - lx)) / area_type'(ux - lx);
            val = ly + longint'(quo);
            ans.region = REGION_INNER;
            twice_area = twice_area + area_type'(val + ly) * area_type'(q - lx);
         end
      end
      twice_area = (twice_area + 1) >>> 1;
      ans.value = val[31:0];
      ans.saturated = 1'b1;
      if (twice_area > area_type'(64'sh7FFF_FFFF_FFFF_FFFF))
         ans.integral = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (twice_area < -area_type'(64'sh7FFF_FFFF_FFFF_FFFF) - 1)
         ans.integral = 64'h8000_0000_0000_0000;
      else begin
         ans.integral = twice_area[63:0];
         ans.saturated = 1'b0;
      end
      return ans;
   endfunction

   task automatic send_beat(logic kind, logic [3:0] idx, logic [31:0] kx,
                            logic [31:0] ky, logic [31:0] qx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_type       <= kind;
      req_knot_index <= idx;
      req_knot_x     <= kx;
      req_knot_y     <= ky;
      req_query_x    <= qx;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      if (kind == REQ_LOAD) begin
         table_x[idx] = kx;
         table_y[idx] = ky;
      end else
         pending_answers.push_back(evaluate_curve(qx));
      beats_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_knot_count(logic [4:0] cnt);
      drain_results();
      csr_write      <= 1'b1;
      csr_knot_count <= cnt;
      @(posedge clock);
      csr_write <= 1'b0;
      count_reg = cnt;
   endtask

   always @(posedge clock) begin
      curve_answer_type exp_ans;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_answers.size() == 0) begin
            $error("result beat arrived with nothing expected");
            failures++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_curve_value !== exp_ans.value) begin
               $error("curve_value expected %h got %h", exp_ans.value, rsp_curve_value);
               failures++;
            end
            if (rsp_curve_integral !== exp_ans.integral) begin
               $error("curve_integral expected %h got %h", exp_ans.integral,
                      rsp_curve_integral);
               failures++;
            end
            if (rsp_region !== exp_ans.region) begin
               $error("region expected %0d got %0d", exp_ans.region, rsp_region);
               failures++;
            end
            if (rsp_saturated !== exp_ans.saturated) begin
               $error("saturated expected %0d got %0d", exp_ans.saturated, rsp_saturated);
               failures++;
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   task automatic test_full_table();
      logic signed [31:0] y;
      set_knot_count(5'd16);
      for (int i = 0; i < 16; i++) begin
         y = (i == 0) ? X_MIN : (i == 15) ? X_MAX : $urandom;
         send_beat(REQ_LOAD, 4'(i), (i == 0) ? X_MIN : (i == 15) ? X_MAX
                   : -32'sd1879048192 + i * 32'sd250000000, y, 0);
      end
      send_beat(REQ_QUERY, 0, 0, 0, X_MIN);
      send_beat(REQ_QUERY, 0, 0, 0, X_MAX);
      send_beat(REQ_QUERY, 0, 0, 0, table_x[7]);
      send_beat(REQ_QUERY, 0, 0, 0, table_x[7] + 32'sd125000000);
      send_beat(REQ_QUERY, 0, 0, 0, table_x[7] - 1);
   endtask

   task automatic test_count_extremes();
      logic [4:0] counts [3] = '{5'd0, 5'd1, 5'd31};
      foreach (counts[c]) begin
         set_knot_count(counts[c]);
         send_beat(REQ_QUERY, 0, 0, 0, X_MIN);
         send_beat(REQ_QUERY, 0, 0, 0, X_MAX);
         send_beat(REQ_QUERY, 0, 0, 0, table_x[0]);
      end
   endtask

   task automatic test_integral_saturation();
      for (int pass = 0; pass < 2; pass++) begin
         set_knot_count(5'd16);
         for (int i = 0; i < 16; i++)
            send_beat(REQ_LOAD, 4'(i), (i % 4 == 0 || i % 4 == 3) ? X_MIN : X_MAX,
                      ((i % 4 < 2) ^ (pass == 1)) ? X_MAX : X_MIN, 0);
         send_beat(REQ_QUERY, 0, 0, 0, X_MAX);
         send_beat(REQ_QUERY, 0, 0, 0, 0);
      end
   endtask

   task automatic test_random_curves(int beat_goal);
      int   stop_at;
      int   n;
      int   shift;
      int   xs[];
      logic [4:0] cnt;
      logic signed [31:0] q;
      stop_at = beats_sent + beat_goal;
      while (beats_sent < stop_at) begin
         cnt = ($urandom_range(9) < 8) ? 5'($urandom_range(2, 8))
                                       : 5'($urandom_range(0, 31));
         set_knot_count(cnt);
         n = (cnt < 1) ? 1 : (cnt > 16) ? 16 : cnt;
         shift = $urandom_range(3) == 0 ? $urandom_range(24) : 0;
         xs = new[n];
         foreach (xs[i]) xs[i] = int'($urandom) >>> shift;
         if ($urandom_range(9) != 0) xs.sort();
         for (int i = 0; i < n; i++)
            send_beat(REQ_LOAD, 4'(i), xs[i], int'($urandom) >>> $urandom_range(16), 0);
         for (int j = 0; j < 12; j++) begin
            case ($urandom_range(3))
               0: q = $urandom;
               1: q = table_x[$urandom_range(n - 1)] + $signed($urandom_range(4)) - 2;
               default: q = table_x[$urandom_range(n - 1)]
                            + (int'($urandom) >>> (shift + $urandom_range(8)));
            endcase
            if ($urandom_range(15) == 0)
               send_beat(REQ_LOAD, 4'($urandom), $urandom, $urandom, $urandom);
            else
               send_beat(REQ_QUERY, 4'($urandom), $urandom, $urandom, q);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_type       = REQ_LOAD;
      req_knot_index = '0;
      req_knot_x     = '0;
      req_knot_y     = '0;
      req_query_x    = '0;
      rsp_pop        = 1'b0;
      csr_write      = 1'b0;
      csr_knot_count = 5'd1;
      count_reg      = 5'd1;
      failures       = 0;
      beats_sent     = 0;
      send_idle_pct  = 20;
      pop_idle_pct   = 87;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_table();
      test_count_extremes();
      test_integral_saturation();
      test_random_curves(650);
      send_idle_pct = 87;
      pop_idle_pct  = 20;
      test_random_curves(650);
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      test_random_curves(650);
      drain_results();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
